// File: sv/job_slot_table_core_assert.svh
// Assertion macros for the job slot table checker.
// Holds macro definitions only; taken in by the checker file.
`ifndef JOB_SLOT_TABLE_CORE_ASSERT_SVH
`define JOB_SLOT_TABLE_CORE_ASSERT_SVH

// Check a property outside reset
`define JST_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define JST_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// File: sv/jst_pkg.sv
// Shared types and constants of the job slot table.
// No dependencies; used by every module of the block.
`default_nettype none

package jst_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int OP_W      = 3;
	localparam int PID_W     = 22;
	localparam int JID_W     = 5;
	localparam int MODE_W    = 2;
	// held job ids keep counting past the 5-bit field after repeated delete/add
	localparam int JOB_W     = 32;
	localparam int S_DATA_W  = 32;
	localparam int M_DATA_W  = 32;

	localparam logic [MODE_W-1:0] MODE_FG = 2'd1;

	typedef enum logic [OP_W-1:0] {
		OP_ADD      = 3'd0,
		OP_DEL      = 3'd1,
		OP_FG       = 3'd2,
		OP_FIND_PID = 3'd3,
		OP_FIND_JOB = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// Command token walking down the cell chain
	typedef struct packed {
		logic              valid;
		op_t               op;
		logic [PID_W-1:0]  pid;
		logic [JOB_W-1:0]  key;    // job id to find, or id to hand out on add
		logic [MODE_W-1:0] mode;
		logic              done;   // search over: hit or rejected
		logic              ok;
		logic [PID_W-1:0]  r_pid;
		logic [JOB_W-1:0]  r_job;
		logic [MODE_W-1:0] r_mode;
		logic [JOB_W-1:0]  mx;     // largest job id seen so far
	} tok_t;

endpackage

`default_nettype wire

// File: sv/jst_cell.sv
// One job slot: holds pid, job id and run state, and acts on the token passing by.
// Depends on jst_pkg.
`default_nettype none

module jst_cell import jst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  tok_t tok_in,
	output tok_t tok_out
);

	logic [PID_W-1:0]  pid_q,  pid_d;
	logic [JOB_W-1:0]  job_q,  job_d;
	logic [MODE_W-1:0] mode_q, mode_d;
	tok_t              tok_q,  tok_d;
	logic              match;
	logic              hit;

	always_comb begin
		case (tok_in.op)
			OP_ADD:                match = (pid_q == '0);
			OP_DEL, OP_FIND_PID:   match = (pid_q == tok_in.pid);
			OP_FG:                 match = (mode_q == MODE_FG);
			OP_FIND_JOB:           match = (job_q == tok_in.key);
			default:               match = 1'b0;
		endcase
		hit = match && tok_in.valid && !tok_in.done;

		tok_d  = tok_in;
		pid_d  = pid_q;
		job_d  = job_q;
		mode_d = mode_q;
		if (hit) begin
			tok_d.done = 1'b1;
			tok_d.ok   = 1'b1;
			if (tok_in.op == OP_ADD) begin
				tok_d.r_pid  = tok_in.pid;
				tok_d.r_job  = tok_in.key;
				tok_d.r_mode = tok_in.mode;
				pid_d        = tok_in.pid;
				job_d        = tok_in.key;
				mode_d       = tok_in.mode;
			end else begin
				tok_d.r_pid  = pid_q;
				tok_d.r_job  = job_q;
				tok_d.r_mode = mode_q;
				if (tok_in.op == OP_DEL) begin
					pid_d  = '0;
					job_d  = '0;
					mode_d = '0;
				end
			end
		end
		// running maximum over the table as it stands after this item
		tok_d.mx = (job_d > tok_in.mx) ? job_d : tok_in.mx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid_q  <= '0;
			job_q  <= '0;
			mode_q <= '0;
			tok_q  <= '0;
		end else begin
			pid_q  <= pid_d;
			job_q  <= job_d;
			mode_q <= mode_d;
			tok_q  <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// File: sv/job_slot_table_core.sv
// Channel | Fields (low bit up)                                   | Item accepted when
// s_*     | tuser: operation; tdata: proc_id, job_number, run_mode | s_tvalid && s_tready
// m_*     | tuser: ok; tdata: found_pid, found_job, found_mode     | m_tvalid && m_tready
//
// Each item walks the chain of SLOTS slot cells, one cell per cycle, from the entry
// register tok0_q; its result is then registered in res_q and in the output register.
// One item is in flight at a time; the next is taken once the result has moved
// to the output register, which may still be waiting on m_tready.
// A stalled output holds the result in the done state. Reset frees every slot
// and sets the next job id to 1; no clearing pass is needed.
`default_nettype none

module job_slot_table_core import jst_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // proc_id[21:0], job_number[26:22], run_mode[28:27]
	input  logic [OP_W-1:0]     s_tuser,   // operation
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // found_pid[21:0], found_job[26:22], found_mode[28:27]
	output logic                m_tuser    // ok
);

	state_t              state_q, state_d;
	tok_t                tok0_q, entry, res_q;
	tok_t                chain [SLOTS+1];
	tok_t                tail;
	logic [JOB_W-1:0]    next_q, next_add;
	logic                m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;
	logic                m_user_q;
	logic                accept, finish, load_out, reject;
	op_t                 op;
	logic [PID_W-1:0]    in_pid;
	logic [JID_W-1:0]    in_job;
	logic [MODE_W-1:0]   in_mode;

	assign chain[0] = tok0_q;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		jst_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	assign tail = chain[SLOTS];

	assign op      = op_t'(s_tuser);
	assign in_pid  = s_tdata[PID_W-1:0];
	assign in_job  = s_tdata[PID_W+JID_W-1:PID_W];
	assign in_mode = s_tdata[PID_W+JID_W+MODE_W-1:PID_W+JID_W];

	always_comb begin
		case (op)
			OP_ADD, OP_DEL, OP_FIND_PID: reject = (in_pid == '0);
			OP_FIND_JOB:                 reject = (in_job == '0);
			OP_FG:                       reject = 1'b0;
			default:                     reject = 1'b1;
		endcase
		entry        = '0;
		entry.valid  = 1'b1;
		entry.op     = op;
		entry.pid    = in_pid;
		entry.key    = (op == OP_ADD) ? next_q : JOB_W'(in_job);
		entry.mode   = in_mode;
		entry.done   = reject;
	end

	assign next_add = (tail.key + JOB_W'(1) > JOB_W'(SLOTS)) ? JOB_W'(1)
	                                                         : tail.key + JOB_W'(1);

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		finish   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_RUN;
			end
			ST_RUN: begin
				finish = tail.valid;
				if (tail.valid) state_d = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register is free
				load_out = !m_valid_q || m_tready;
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_q    <= '0;
			next_q    <= JOB_W'(1);
			m_valid_q <= 1'b0;
		end else begin
			tok0_q <= accept ? entry : '0;
			if (finish && tail.ok) begin
				if (tail.op == OP_ADD) begin
					next_q <= next_add;
				end else if (tail.op == OP_DEL) begin
					next_q <= tail.mx + JOB_W'(1);
				end
			end
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			res_q <= tail;
		end
		if (load_out) begin
			m_user_q <= res_q.ok;
			m_data_q <= {(M_DATA_W-PID_W-JID_W-MODE_W)'(0), res_q.r_mode,
			             res_q.r_job[JID_W-1:0], res_q.r_pid};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

`default_nettype wire

// File: sv/jst_checker.sv
// Port-level checks for job_slot_table_core, bound to every instance.
// Depends on jst_pkg and job_slot_table_core_assert.svh.
`default_nettype none

`include "job_slot_table_core_assert.svh"

module jst_checker import jst_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tuser
);

	`JST_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`JST_ASSERT(a_miss_zero, clk, arst_n, m_tvalid && !m_tuser |-> m_tdata == '0, "failed result carries data")
	`JST_ASSERT(a_hit_pid, clk, arst_n, m_tvalid && m_tuser |-> m_tdata[PID_W-1:0] != '0, "found entry has zero pid")
	`JST_ASSERT(a_one_item, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "second item taken while busy")
	`JST_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |=> !m_tvalid, "result shown during reset")

endmodule

bind job_slot_table_core jst_checker u_jst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
